/* hdl/omd_pkg.sv */
// Package for the optical Morse letter decoder: shared constants, config
// register codes, the letter table and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package omd_pkg;

  // Default widths handed to the top-level parameters
  localparam int unsigned TIMER_BITS_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Config port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CHAR_W     = 7;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_OFFSET   = 3'd0,
    CFG_LIGHT_THRESHOLD = 3'd1,
    CFG_DOT_LIMIT       = 3'd2,
    CFG_DASH_LIMIT      = 3'd3,
    CFG_LETTER_GAP      = 3'd4,
    CFG_WORD_GAP        = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_OFFSET   = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_LIGHT_THRESHOLD = 16'd20;
  localparam logic [LIMIT_W-1:0]    RST_DOT_LIMIT       = 16'd340;
  localparam logic [LIMIT_W-1:0]    RST_DASH_LIMIT      = 16'd1040;
  localparam logic [LIMIT_W-1:0]    RST_LETTER_GAP      = 16'd800;
  localparam logic [LIMIT_W-1:0]    RST_WORD_GAP        = 16'd1200;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 7'd90;

  // Letters grouped by symbol count; group of length n starts at 2^n - 2,
  // symbol i sits in bit i, dot is 0 and dash is 1.
  localparam logic [CHAR_W-1:0] LETTER_TAB [30] = '{
    7'd69, 7'd84,                                           // E T
    7'd73, 7'd78, 7'd65, 7'd77,                             // I N A M
    7'd83, 7'd68, 7'd82, 7'd71, 7'd85, 7'd75, 7'd87, 7'd79, // S D R G U K W O
    7'd72, 7'd66, 7'd76, 7'd90, 7'd70, 7'd67, 7'd80, 7'd32, // H B L Z F C P -
    7'd86, 7'd88, 7'd32, 7'd81, 7'd32, 7'd89, 7'd74, 7'd32  // V X - Q - Y J -
  };

  // Timing limits, all fixed 16-bit registers
  typedef struct packed {
    logic [LIMIT_W-1:0] dot_limit;
    logic [LIMIT_W-1:0] dash_limit;
    logic [LIMIT_W-1:0] letter_gap;
    logic [LIMIT_W-1:0] word_gap;
  } limits_t;

  // One decoded result
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] char_code;
    logic              is_word_space;
  } result_t;

  // Map a collected symbol pattern to ASCII; an empty or long pattern is a space
  function automatic logic [CHAR_W-1:0] letter_of(input logic [2:0] count,
                                                  input logic [3:0] bits);
    logic [4:0] idx;
    logic       known;
    idx   = '0;
    known = 1'b1;
    unique case (count)
      3'd1:    idx = 5'd0 + {4'd0, bits[0]};
      3'd2:    idx = 5'd2 + {3'd0, bits[1:0]};
      3'd3:    idx = 5'd6 + {2'd0, bits[2:0]};
      3'd4:    idx = 5'd14 + {1'b0, bits};
      default: known = 1'b0;
    endcase
    return known ? LETTER_TAB[idx] : CHAR_SPACE;
  endfunction

endpackage

/* hdl/omd_tracker.sv */
// Pulse and gap tracker of the optical Morse decoder: light detection, pulse
// and dark timers, symbol collection and letter / word-space decisions.
// Depends on omd_pkg.
`timescale 1ns / 1ps

module omd_tracker #(
  parameter int unsigned TIMER_BITS  = omd_pkg::TIMER_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = omd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,       // commit this sample's update
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] offset_i,
  input  logic [SAMPLE_BITS-1:0] threshold_i,
  input  omd_pkg::limits_t       limits_i,
  output omd_pkg::result_t       result_o
);
  import omd_pkg::*;

  localparam int unsigned CW = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  logic                   light_q, light_d;
  logic [TIMER_BITS-1:0]  dark_q, dark_d;
  logic [TIMER_BITS-1:0]  pulse_q, pulse_d;
  logic [3:0]             bits_q, bits_d;
  logic [2:0]             count_q, count_d;
  logic                   frozen_q, frozen_d;
  logic                   pend_q, pend_d;

  logic [SAMPLE_BITS-1:0] level;
  logic [TIMER_BITS-1:0]  pulse_inc, dark_inc;
  logic [CW-1:0]          pulse_x, dark_x;
  logic                   is_dot, is_dash_ok;
  result_t                res;

  // Offset removal, saturating at zero
  assign level = (sample_i >= offset_i) ? (sample_i - offset_i) : '0;

  // Saturating timer increments
  assign pulse_inc = (pulse_q == '1) ? pulse_q : pulse_q + 1'b1;
  assign dark_inc  = (dark_q == '1) ? dark_q : dark_q + 1'b1;

  assign pulse_x    = CW'(pulse_q);
  assign dark_x     = CW'(dark_inc);
  assign is_dot     = pulse_x < CW'(limits_i.dot_limit);
  assign is_dash_ok = pulse_x < CW'(limits_i.dash_limit);

  // Next-state and result logic for one sample
  always_comb begin
    light_d  = light_q;
    dark_d   = dark_q;
    pulse_d  = pulse_q;
    bits_d   = bits_q;
    count_d  = count_q;
    frozen_d = frozen_q;
    pend_d   = pend_q;
    res      = '0;
    if (light_q) begin
      if (level > threshold_i) begin
        pulse_d = pulse_inc;
      end else begin
        // pulse ends: classify its length
        light_d = 1'b0;
        dark_d  = '0;
        if (!frozen_q) begin
          if (is_dot || is_dash_ok) begin
            if (count_q < 3'd4) begin
              bits_d[count_q[1:0]] = bits_q[count_q[1:0]] | !is_dot;
            end
            if (count_q < 3'd5) begin
              count_d = count_q + 3'd1;
            end
          end else begin
            frozen_d = 1'b1;
          end
        end
      end
    end else if (level >= threshold_i) begin
      light_d = 1'b1;
      pulse_d = TIMER_BITS'(1);
    end else begin
      dark_d = dark_inc;
      if (count_q != 3'd0 || frozen_q) begin
        // letter gap after symbols
        if (dark_x > CW'(limits_i.letter_gap)) begin
          res.valid         = 1'b1;
          res.char_code     = letter_of(count_q, bits_q);
          res.is_word_space = 1'b0;
          bits_d            = '0;
          count_d           = '0;
          frozen_d          = 1'b0;
          pend_d            = 1'b1;
          dark_d            = '0;
        end
      end else if (dark_x > CW'(limits_i.word_gap)) begin
        // word gap, only once after a letter
        dark_d = '0;
        if (pend_q) begin
          pend_d            = 1'b0;
          res.valid         = 1'b1;
          res.char_code     = CHAR_SPACE;
          res.is_word_space = 1'b1;
        end
      end
    end
  end

  assign result_o = res;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q  <= 1'b0;
      dark_q   <= '0;
      pulse_q  <= '0;
      bits_q   <= '0;
      count_q  <= '0;
      frozen_q <= 1'b0;
      pend_q   <= 1'b0;
    end else if (step_i) begin
      light_q  <= light_d;
      dark_q   <= dark_d;
      pulse_q  <= pulse_d;
      bits_q   <= bits_d;
      count_q  <= count_d;
      frozen_q <= frozen_d;
      pend_q   <= pend_d;
    end
  end

endmodule

/* hdl/optical_morse_letter_decoder.sv */
// Optical Morse letter decoder: one light-sensor sample per millisecond tick
// in, decoded letters and word spaces out. The decoder takes one sample per
// clock cycle while the output is not stalled: a sample is held in the input
// register, and the combinational tracker update commits it and places its
// result, if any, in the output register. A stalled output holds the
// pipeline; the input register keeps taking samples while it is empty or the
// output is free or being taken. Config writes are always accepted and take
// effect at once; write them only while the decoder is idle.
// Depends on omd_pkg and omd_tracker.
`timescale 1ns / 1ps

module optical_morse_letter_decoder #(
  parameter int unsigned TIMER_BITS  = omd_pkg::TIMER_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = omd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [omd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [omd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // sample stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
  // character stream out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // char_code
  output logic                                 m_axis_tuser   // is_word_space
);
  import omd_pkg::*;

  // Config registers
  logic [SAMPLE_BITS-1:0] offset_q, threshold_q;
  limits_t                limits_q;

  // Input stage
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;

  // Output stage
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      out_char_q;
  logic                   out_space_q;

  logic                   adv;
  result_t                res;

  assign cfg_ready_o = 1'b1;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q            <= RST_SAMPLE_OFFSET[SAMPLE_BITS-1:0];
      threshold_q         <= RST_LIGHT_THRESHOLD[SAMPLE_BITS-1:0];
      limits_q.dot_limit  <= RST_DOT_LIMIT;
      limits_q.dash_limit <= RST_DASH_LIMIT;
      limits_q.letter_gap <= RST_LETTER_GAP;
      limits_q.word_gap   <= RST_WORD_GAP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_OFFSET:   offset_q            <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_LIGHT_THRESHOLD: threshold_q         <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_DOT_LIMIT:       limits_q.dot_limit  <= cfg_data_i[LIMIT_W-1:0];
        CFG_DASH_LIMIT:      limits_q.dash_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_LETTER_GAP:      limits_q.letter_gap <= cfg_data_i[LIMIT_W-1:0];
        CFG_WORD_GAP:        limits_q.word_gap   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances when the output register is empty or being drained
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  omd_tracker #(
    .TIMER_BITS (TIMER_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_valid_q && adv),
    .sample_i   (s1_sample_q),
    .offset_i   (offset_q),
    .threshold_i(threshold_q),
    .limits_i   (limits_q),
    .result_o   (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && res.valid) begin
      out_char_q  <= res.char_code;
      out_space_q <= res.is_word_space;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tuser  = out_space_q;

`ifndef SYNTH
  // A word space always carries the space character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6:0] == CHAR_SPACE)
    else $error("word space with a non-space character");

  // A letter result is A-Z or a space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[6:0] == CHAR_SPACE) ||
      (m_axis_tdata[6:0] >= CHAR_A && m_axis_tdata[6:0] <= CHAR_Z))
    else $error("letter result outside A-Z and space");

  // A sample held in the input register is not lost while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_sample_q))
    else $error("input stage dropped a sample during a stall");
`endif

endmodule
